/* src/bcq_pkg.sv */
// Package for the button change event queue.
// Holds the shared constants, request codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package bcq_pkg;

  localparam int unsigned NUM_BUTTONS = 11;
  localparam int unsigned LEVEL_W     = 11;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned LEFT_W      = 5;
  localparam int unsigned LEFT_MAX    = 31;
  localparam int unsigned EVENT_W     = CODE_W + 1;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef struct packed {
    logic report_start;
    logic scan_step;
    logic pop_read;
    logic pop_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic primed;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/bcq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the event ring of the button change event queue. No dependencies.
`default_nettype none

module bcq_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/bcq_ctrl.sv */
// Controller state machine of the button change event queue.
// Sequences report scans and pops; depends on bcq_pkg.
`default_nettype none

module bcq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                req_type_i,
  output logic                     in_stall_o,
  input  wire bcq_pkg::dp_status_t status_i,
  output bcq_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   accept;

  assign accept = in_valid_i && !stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == bcq_pkg::REQ_POP) begin
            cmd_o.pop_read = 1'b1;
            state_d        = ST_POP;
          end else begin
            cmd_o.report_start = 1'b1;
            if (status_i.primed) begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.pop_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    stall_d = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

/* src/bcq_dp.sv */
// Datapath of the button change event queue: level registers, ring pointers,
// event RAM and output register. Depends on bcq_pkg and bcq_ram.
`default_nettype none

module bcq_dp #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bcq_pkg::LEVEL_W-1:0]   button_levels_i,
  input  wire bcq_pkg::ctrl_cmd_t            cmd_i,
  output bcq_pkg::dp_status_t                status_o,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic                               event_valid_o,
  output logic [bcq_pkg::CODE_W-1:0]         button_code_o,
  output logic                               released_o,
  output logic [bcq_pkg::LEFT_W-1:0]         events_left_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [bcq_pkg::CODE_W-1:0] IDX_LAST = bcq_pkg::CODE_W'(bcq_pkg::NUM_BUTTONS - 1);

  logic [bcq_pkg::LEVEL_W-1:0] prev_q, levels_q;
  logic                        primed_q;
  logic [bcq_pkg::CODE_W-1:0]  idx_q;
  logic [PTR_W-1:0]            rp_q, wp_q, rp_next, wp_next;
  logic                        bit_prev, bit_now, bit_change;
  logic [bcq_pkg::EVENT_W-1:0] wdata, rdata;
  logic                        ring_empty;
  logic [CNT_W-1:0]            pending;
  logic                        out_valid_q, event_valid_q, released_q;
  logic [bcq_pkg::CODE_W-1:0]  code_q;
  logic [bcq_pkg::LEFT_W-1:0]  left_q;
  logic                        out_free;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign bit_prev   = prev_q[idx_q];
  assign bit_now    = levels_q[idx_q];
  assign bit_change = bit_prev ^ bit_now;
  assign wdata      = {bit_prev, idx_q};
  assign wp_next    = ptr_inc(wp_q);
  assign rp_next    = ptr_inc(rp_q);
  assign ring_empty = (rp_q == wp_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (wp_q >= rp_next) begin
      pending = CNT_W'(wp_q) - CNT_W'(rp_next);
    end else begin
      pending = CNT_W'(wp_q) + CNT_W'(RING_DEPTH) - CNT_W'(rp_next);
    end
  end

  bcq_ram #(
    .WIDTH(bcq_pkg::EVENT_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.scan_step && bit_change),
    .waddr_i(wp_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.pop_read),
    .raddr_i(rp_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      primed_q    <= 1'b0;
      idx_q       <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.report_start) begin
        idx_q <= '0;
        if (!primed_q) begin
          prev_q   <= button_levels_i;
          primed_q <= 1'b1;
        end
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + bcq_pkg::CODE_W'(1);
        if (bit_change) begin
          wp_q <= wp_next;
          if (wp_next == rp_q) begin
            rp_q <= rp_next;
          end
        end
        if (idx_q == IDX_LAST) begin
          prev_q <= levels_q;
        end
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.pop_load) begin
        out_valid_q <= 1'b1;
        if (!ring_empty) begin
          rp_q <= rp_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report_start) begin
      levels_q <= button_levels_i;
    end
    if (cmd_i.pop_load) begin
      if (ring_empty) begin
        event_valid_q <= 1'b0;
        code_q        <= '0;
        released_q    <= 1'b0;
        left_q        <= '0;
      end else begin
        event_valid_q <= 1'b1;
        code_q        <= rdata[bcq_pkg::CODE_W-1:0];
        released_q    <= rdata[bcq_pkg::CODE_W];
        if (int'(pending) > int'(bcq_pkg::LEFT_MAX)) begin
          left_q <= bcq_pkg::LEFT_W'(bcq_pkg::LEFT_MAX);
        end else begin
          left_q <= bcq_pkg::LEFT_W'(pending);
        end
      end
    end
  end

  assign status_o.primed    = primed_q;
  assign status_o.scan_last = (idx_q == IDX_LAST);
  assign status_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = event_valid_q;
  assign button_code_o = code_q;
  assign released_o    = released_q;
  assign events_left_o = left_q;

endmodule

`default_nettype wire

/* src/button_change_event_queue.sv */
// Top level of the button change event queue.
// Joins bcq_ctrl and bcq_dp; depends on bcq_pkg.
//
// The input channel takes requests: req_type_i = 0 is a report of the 11
// button levels, req_type_i = 1 pops the oldest queued event. A request is
// accepted when in_valid_i is high and in_stall_o is low. The first report
// after reset only primes the stored levels. Each later report scans the
// buttons one per cycle through the ring's single write port. Every
// change queues a press or release event, and on overflow the oldest
// event is dropped. A pop gives one result on the output channel: the RAM
// read data is registered on acceptance, and the output register loads it
// once that register is free, so a stalled receiver delays the load.
// An empty ring gives a result with event_valid_o low and zero fields.
// A result is taken when out_valid_o is high and out_stall_i is low. While
// the receiver stalls, the result holds and reports are still processed; a
// further pop is accepted but then stalls the input until the output
// register is free.
// Reset clears the stored levels, the primed flag, both ring pointers and out_valid_o.
`default_nettype none

module button_change_event_queue #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        req_type_i,
  input  wire logic [bcq_pkg::LEVEL_W-1:0] button_levels_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             event_valid_o,
  output logic [bcq_pkg::CODE_W-1:0]       button_code_o,
  output logic                             released_o,
  output logic [bcq_pkg::LEFT_W-1:0]       events_left_o
);

  bcq_pkg::ctrl_cmd_t  cmd;
  bcq_pkg::dp_status_t status;

  bcq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_type_i(req_type_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bcq_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .button_levels_i(button_levels_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .event_valid_o  (event_valid_o),
    .button_code_o  (button_code_o),
    .released_o     (released_o),
    .events_left_o  (events_left_o)
  );

endmodule

`default_nettype wire

/* src/bcq_checker.sv */
// Port-level checker for the button change event queue, bound to the top.
// Depends on bcq_pkg and button_change_event_queue.
`default_nettype none

module bcq_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        req_type_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        event_valid_o,
  input wire logic [bcq_pkg::CODE_W-1:0]  button_code_o,
  input wire logic                        released_o,
  input wire logic [bcq_pkg::LEFT_W-1:0]  events_left_o
);

  logic pop_accept;

  assign pop_accept = in_valid_i && !in_stall_o && (req_type_i == bcq_pkg::REQ_POP);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_valid_o)
      && $stable(button_code_o) && $stable(released_o) && $stable(events_left_o))
    else $error("Stalled result changed.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> button_code_o == '0 && !released_o
      && events_left_o == '0)
    else $error("Empty-ring result carries nonzero fields.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |->
      button_code_o <= bcq_pkg::CODE_W'(bcq_pkg::NUM_BUTTONS - 1))
    else $error("Button code out of range.");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_accept |=> in_stall_o)
    else $error("Pop request did not occupy the block.");

endmodule

bind button_change_event_queue bcq_checker u_bcq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_valid_o(event_valid_o),
  .button_code_o(button_code_o),
  .released_o   (released_o),
  .events_left_o(events_left_o)
);

`default_nettype wire
